@@ hw/rtl/sjdec_pkg.sv @@
// ----------------------------------------------------------------------------
// sjdec_pkg
// Shared types and constants for the Shift-JIS to UTF-8 decoder unit.
// ----------------------------------------------------------------------------
package sjdec_pkg;

    localparam int TABLE_WORDS = 16384;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int IDX_W       = 14;
    localparam int CODE_W      = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_END    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // lead nibbles and base rows of the double-byte regions
    localparam logic [3:0] LEAD_NIB_8 = 4'h8;
    localparam logic [3:0] LEAD_NIB_9 = 4'h9;
    localparam logic [3:0] LEAD_NIB_E = 4'hE;
    localparam logic [5:0] ROW_BASE_8 = 6'h01;
    localparam logic [5:0] ROW_BASE_9 = 6'h11;
    localparam logic [5:0] ROW_BASE_E = 6'h21;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } sjdec_code_t;

endpackage

@@ hw/rtl/sjdec_front.sv @@
// ----------------------------------------------------------------------------
// sjdec_front
// Accepts requests, tracks the pending lead byte, loads and reads the table.
// ----------------------------------------------------------------------------
module sjdec_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_action,
    input  logic [7:0]                     in_byte,
    input  logic [sjdec_pkg::IDX_W-1:0]    in_index,
    input  logic [sjdec_pkg::CODE_W-1:0]   in_word,
    input  logic [sjdec_pkg::QCNT_W-1:0]   q_count,
    output sjdec_pkg::sjdec_code_t         code_out
);

    localparam logic [sjdec_pkg::ADDR_W:0] TABLE_LIMIT =
        (sjdec_pkg::ADDR_W + 1)'(sjdec_pkg::TABLE_WORDS);

    logic [sjdec_pkg::CODE_W-1:0] mem [0:sjdec_pkg::TABLE_WORDS-1];

    logic                          lead_pending_reg, lead_pending_next;
    logic [7:0]                    lead_byte_reg, lead_byte_next;
    logic                          rd_valid_reg;
    logic [sjdec_pkg::CODE_W-1:0]  rd_data_reg;

    logic                          accept;
    logic                          wr_en;
    logic                          rd_en;
    logic [sjdec_pkg::IDX_W-1:0]   rd_idx;
    logic [5:0]                    row_base;
    logic [5:0]                    row;
    logic [3:0]                    nib;
    logic [sjdec_pkg::QCNT_W:0]    used;

    assign used     = {1'b0, q_count} + {{sjdec_pkg::QCNT_W{1'b0}}, rd_valid_reg};
    assign in_ready = used < (sjdec_pkg::QCNT_W + 1)'(sjdec_pkg::QDEPTH);
    assign accept   = in_valid && in_ready;
    assign nib      = in_byte[7:4];

    always_comb begin
        case (lead_byte_reg[7:4])
            sjdec_pkg::LEAD_NIB_8: row_base = sjdec_pkg::ROW_BASE_8;
            sjdec_pkg::LEAD_NIB_9: row_base = sjdec_pkg::ROW_BASE_9;
            default:               row_base = sjdec_pkg::ROW_BASE_E;
        endcase
        row = row_base + {2'b00, lead_byte_reg[3:0]};
    end

    always_comb begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        rd_idx            = {6'd0, in_byte};
        if (accept) begin
            case (sjdec_pkg::action_t'(in_action))
                sjdec_pkg::ACT_WRITE: begin
                    wr_en = ({1'b0, in_index} < (sjdec_pkg::IDX_W + 1)'(TABLE_LIMIT));
                end
                sjdec_pkg::ACT_END: begin
                    lead_pending_next = 1'b0;
                    lead_byte_next    = 8'd0;
                end
                sjdec_pkg::ACT_DECODE: begin
                    if (lead_pending_reg) begin
                        rd_en             = 1'b1;
                        rd_idx            = {row, in_byte};
                        lead_pending_next = 1'b0;
                        lead_byte_next    = 8'd0;
                    end else if (nib == sjdec_pkg::LEAD_NIB_8 ||
                                 nib == sjdec_pkg::LEAD_NIB_9 ||
                                 nib == sjdec_pkg::LEAD_NIB_E) begin
                        lead_pending_next = 1'b1;
                        lead_byte_next    = in_byte;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_index[sjdec_pkg::ADDR_W-1:0]] <= in_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx[sjdec_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'd0;
            rd_valid_reg     <= 1'b0;
        end else begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            rd_valid_reg     <= rd_en;
        end
    end

    assign code_out.valid = rd_valid_reg;
    assign code_out.code  = rd_data_reg;

endmodule

@@ hw/rtl/sjdec_queue.sv @@
// ----------------------------------------------------------------------------
// sjdec_queue
// Short queue of looked-up code points between front and emitter.
// ----------------------------------------------------------------------------
module sjdec_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sjdec_pkg::sjdec_code_t        push,
    input  logic                          pop,
    output logic                          not_empty,
    output logic [sjdec_pkg::CODE_W-1:0]  head,
    output logic [sjdec_pkg::QCNT_W-1:0]  count
);

    logic [sjdec_pkg::CODE_W-1:0] entry_reg [0:sjdec_pkg::QDEPTH-1];
    logic [sjdec_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sjdec_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sjdec_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                         do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/sjdec_emit.sv @@
// ----------------------------------------------------------------------------
// sjdec_emit
// Expands each code point into one to three UTF-8 bytes on the result side.
// ----------------------------------------------------------------------------
module sjdec_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  logic [sjdec_pkg::CODE_W-1:0]  q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  rem_reg, rem_next;

    logic [7:0]  b0, b1, b2;
    logic [1:0]  n_rem;
    logic        take;
    logic        shift;

    always_comb begin
        b1 = {2'b10, q_head[5:0]};
        b2 = 8'd0;
        if (q_head < 16'h0080) begin
            b0    = q_head[7:0];
            n_rem = 2'd0;
        end else if (q_head < 16'h0800) begin
            b0    = {3'b110, q_head[10:6]};
            n_rem = 2'd1;
        end else begin
            b0    = {4'b1110, q_head[15:12]};
            b1    = {2'b10, q_head[11:6]};
            b2    = {2'b10, q_head[5:0]};
            n_rem = 2'd2;
        end
    end

    assign shift = out_valid_reg && out_ready && (rem_reg != 2'd0);
    assign take  = (!out_valid_reg || (out_ready && rem_reg == 2'd0)) && q_not_empty;
    assign q_pop = take;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        if (shift) begin
            out_byte_next = pend_reg[15:8];
            out_last_next = (rem_reg == 2'd1);
            pend_next     = {pend_reg[7:0], 8'd0};
            rem_next      = rem_reg - 2'd1;
        end else if (take) begin
            out_valid_next = 1'b1;
            out_byte_next  = b0;
            out_last_next  = (n_rem == 2'd0);
            pend_next      = {b1, b2};
            rem_next       = n_rem;
        end else if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        pend_reg     <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rem_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hw/rtl/shift_jis_to_utf8_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// shift_jis_to_utf8_decoder_unit
// Shift-JIS byte stream to UTF-8 through a loadable 16-bit code table.
//
//   channel  dir  tdata                                     tuser      tlast
//   s_       in   [7:0] in_byte [21:8] table_index           action     -
//                 [37:22] table_word, [39:38] zero
//   m_       out  [7:0] out_byte                            -          char_last
//
// a table write, end of string or lead byte reads nothing from the table
// a completed character yields one to three bytes, one per cycle on m_ while m_tready is high
// the table read is registered, then the code waits in a four-entry queue
// the input stalls only when the queue, counting the read in flight, is full
// aresetn clears the lead byte, queue and output stage, not the table
// ----------------------------------------------------------------------------
module shift_jis_to_utf8_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // in_byte, table_index, table_word, pad
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    sjdec_pkg::sjdec_code_t        code;
    logic                          q_pop;
    logic                          q_not_empty;
    logic [sjdec_pkg::CODE_W-1:0]  q_head;
    logic [sjdec_pkg::QCNT_W-1:0]  q_count;

    sjdec_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_index  (s_tdata[21:8]),
        .in_word   (s_tdata[37:22]),
        .q_count   (q_count),
        .code_out  (code)
    );

    sjdec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (code),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    sjdec_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

@@ sim/tb_shift_jis_to_utf8_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_shift_jis_to_utf8_decoder_unit
// Self-checking testbench for the Shift-JIS to UTF-8 decoder unit.
// Loads part of the code table, then streams directed and random characters
// with bursty requests and a stalling output side. A local model of the
// decoder predicts every UTF-8 byte and its last flag, checked in order.
// Decode bytes only ever address table entries that were written before.
// ----------------------------------------------------------------------------
module tb_shift_jis_to_utf8_decoder_unit;
    import sjdec_pkg::*;

    typedef struct {
        action_t     act;
        logic [7:0]  sj_byte;
        logic [13:0] idx;
        logic [15:0] word;
    } sj_req_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } utf8_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // in_byte, table_index, table_word, pad
    logic [1:0]  s_tuser = ACT_WRITE;  // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // out_byte
    logic        m_tlast;          // char_last

    shift_jis_to_utf8_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    sj_req_t    pending_reqs [$];
    utf8_byte_t utf8_expect [$];
    sj_req_t    cur_req;
    bit         offer_taken = 1'b0;

    // decoder model state
    logic [CODE_W-1:0] code_mem [TABLE_WORDS];
    bit                lead_held = 1'b0;
    logic [7:0]        lead_val = '0;

    // request generator bookkeeping
    bit          gen_written [TABLE_WORDS];
    logic [7:0]  single_ok [$];
    logic [13:0] double_ok [$];
    int          gen_count = 0;

    int errors = 0;
    int n_writes = 0, n_decodes = 0, n_ends = 0, n_nones = 0;
    int results_seen = 0, chars_seen = 0, stall_cycles = 0;
    int burst_left = 8, gap_left = 0;
    int rx_mode = 0, mode_left = 0, hold_cnt = 0;
    bit hold_done = 1'b0;

    function automatic bit is_lead(input logic [7:0] b);
        return b[7:4] == LEAD_NIB_8 || b[7:4] == LEAD_NIB_9 || b[7:4] == LEAD_NIB_E;
    endfunction

    task automatic add_expect(input logic [7:0] value, input logic last);
        utf8_byte_t item;
        item.value = value;
        item.last  = last;
        utf8_expect.insert(utf8_expect.size(), item);
    endtask

    task automatic decode_to_utf8(input sj_req_t r);
        logic [5:0]        row;
        logic [13:0]       idx;
        logic [CODE_W-1:0] cp;
        bit                have_char;
        have_char = 1'b0;
        idx = '0;
        case (r.act)
            ACT_WRITE: begin
                n_writes++;
                if (int'(r.idx) < TABLE_WORDS) code_mem[r.idx] = r.word;
            end
            ACT_END: begin
                n_ends++;
                lead_held = 1'b0;
                lead_val = '0;
            end
            ACT_DECODE: begin
                n_decodes++;
                if (lead_held) begin
                    case (lead_val[7:4])
                        LEAD_NIB_8: row = ROW_BASE_8;
                        LEAD_NIB_9: row = ROW_BASE_9;
                        default:    row = ROW_BASE_E;
                    endcase
                    row = row + {2'b00, lead_val[3:0]};
                    idx = {row, r.sj_byte};
                    lead_held = 1'b0;
                    lead_val = '0;
                    have_char = 1'b1;
                end else if (is_lead(r.sj_byte)) begin
                    lead_held = 1'b1;
                    lead_val = r.sj_byte;
                end else begin
                    idx = {6'd0, r.sj_byte};
                    have_char = 1'b1;
                end
            end
            default: n_nones++;
        endcase
        if (have_char) begin
            cp = (int'(idx) < TABLE_WORDS) ? code_mem[idx] : '0;
            if (cp < 16'h0080) begin
                add_expect(cp[7:0], 1'b1);
            end else if (cp < 16'h0800) begin
                add_expect(8'hC0 | {3'b000, cp[10:6]}, 1'b0);
                add_expect(8'h80 | {2'b00, cp[5:0]}, 1'b1);
            end else begin
                add_expect(8'hE0 | {4'h0, cp[15:12]}, 1'b0);
                add_expect(8'h80 | {2'b00, cp[11:6]}, 1'b0);
                add_expect(8'h80 | {2'b00, cp[5:0]}, 1'b1);
            end
        end
    endtask

    function automatic logic [15:0] rand_code();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [13:0] rand_widx();
        case ($urandom_range(0, 2))
            0: return 14'($urandom_range(0, 255));
            1: return 14'(14'h100 + $urandom_range(0, 14'h2FFF));
            default: return 14'($urandom_range(0, TABLE_WORDS - 1));
        endcase
    endfunction

    task automatic push_req(input action_t act, input logic [7:0] b,
                            input logic [13:0] idx, input logic [15:0] word);
        sj_req_t r;
        r.act = act;
        r.sj_byte = b;
        r.idx = idx;
        r.word = word;
        pending_reqs.insert(pending_reqs.size(), r);
        if (act != ACT_NONE) gen_count++;
    endtask

    task automatic push_write(input logic [13:0] idx, input logic [15:0] word);
        push_req(ACT_WRITE, 8'($urandom), idx, word);
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            if (idx < 14'h100 && !is_lead(idx[7:0])) begin
                single_ok.insert(single_ok.size(), idx[7:0]);
            end else if (idx >= 14'h100 && idx <= 14'h30FF) begin
                double_ok.insert(double_ok.size(), idx);
            end
        end
    endtask

    task automatic push_decode(input logic [7:0] b);
        push_req(ACT_DECODE, b, 14'($urandom), 16'($urandom));
    endtask

    task automatic push_end();
        push_req(ACT_END, 8'($urandom), 14'($urandom), 16'($urandom));
    endtask

    task automatic push_none();
        push_req(ACT_NONE, 8'($urandom), 14'($urandom), 16'($urandom));
    endtask

    // noise: 0 clean, 1 write between, 2 unused code between, 3 end drops lead
    task automatic push_double(input logic [13:0] idx, input int noise);
        logic [13:0] off;
        logic [3:0]  nib;
        if (idx < 14'h1100) begin
            nib = LEAD_NIB_8;
            off = idx - 14'h100;
        end else if (idx < 14'h2100) begin
            nib = LEAD_NIB_9;
            off = idx - 14'h1100;
        end else begin
            nib = LEAD_NIB_E;
            off = idx - 14'h2100;
        end
        push_decode({nib, off[11:8]});
        if (noise == 3) begin
            push_end();
        end else begin
            if (noise == 1) push_write(rand_widx(), rand_code());
            if (noise == 2) push_none();
            push_decode(off[7:0]);
        end
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !offer_taken)) begin
            offer_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, cur_req.word, cur_req.idx, cur_req.sj_byte};
                s_tuser <= cur_req.act;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = $urandom_range(0, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_to_utf8(cur_req);
                offer_taken = 1'b1;
            end else if (s_tvalid) begin
                stall_cycles++;
            end
        end
    end

    // output side readiness, with one long hold-off to back up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 60) begin
            hold_done = 1'b1;
            hold_cnt = 250;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : out_monitor
        utf8_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tlast) chars_seen++;
            if (utf8_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = utf8_expect.pop_front();
                if (m_tdata !== want.value) begin
                    errors++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.value, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: char_last mismatch, expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    initial begin
        int roll;
        int noise;
        int rand_stop;

        // table preload in both regions
        repeat (24) push_write(14'($urandom_range(0, 255)), rand_code());
        repeat (24) push_write(14'(14'h100 + $urandom_range(0, 14'h2FFF)), rand_code());

        // code extremes and region corners
        push_write(14'h0000, 16'h0000);
        push_write(14'h00FF, 16'hFFFF);
        push_write(14'h007F, 16'h007F);
        push_write(14'h0041, 16'h0080);
        push_write(14'h0100, 16'h07FF);
        push_write(14'h10FF, 16'h0800);
        push_write(14'h1100, 16'h0041);
        push_write(14'h20FF, 16'h1234);
        push_write(14'h2100, 16'hABCD);
        push_write(14'h30FF, 16'h07C0);
        push_write(14'h029A, 16'h3000);
        push_write(14'h3FFF, 16'h5555);
        push_decode(8'h00);
        push_decode(8'hFF);
        push_decode(8'h7F);
        push_decode(8'h41);
        push_double(14'h0100, 0);
        push_double(14'h10FF, 0);
        push_double(14'h1100, 0);
        push_double(14'h20FF, 0);
        push_double(14'h2100, 0);
        push_double(14'h30FF, 0);
        // second byte that is itself a lead byte
        push_double(14'h029A, 0);
        // end of string drops the lead
        push_double(14'h029A, 3);
        // write while a lead is held, to the entry about to be read
        push_decode(8'h81);
        push_write(14'h029A, 16'h00E9);
        push_decode(8'h9A);
        push_double(14'h029A, 2);
        push_none();
        push_end();

        rand_stop = gen_count + 310;
        while (gen_count < rand_stop) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                push_write(rand_widx(), rand_code());
            end else if (roll < 16) begin
                push_end();
            end else if (roll < 19) begin
                push_none();
            end else if (roll < 45) begin
                push_decode(single_ok[$urandom_range(0, single_ok.size() - 1)]);
            end else begin
                noise = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 3);
                push_double(double_ok[$urandom_range(0, double_ok.size() - 1)], noise);
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || utf8_expect.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests (%0d writes, %0d decodes, %0d ends, %0d unused)",
                 n_writes + n_decodes + n_ends + n_nones, n_writes, n_decodes, n_ends,
                 n_nones);
        $display("checked %0d output bytes in %0d characters, input held off %0d cycles",
                 results_seen, chars_seen, stall_cycles);
        if (errors == 0) begin
            $display("PASS shift_jis_to_utf8_decoder_unit");
        end else begin
            $display("FAIL shift_jis_to_utf8_decoder_unit");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("FAIL shift_jis_to_utf8_decoder_unit");
        $finish;
    end

endmodule

@@ shift_jis_to_utf8_decoder_unit.f @@
hw/rtl/sjdec_pkg.sv
hw/rtl/sjdec_front.sv
hw/rtl/sjdec_queue.sv
hw/rtl/sjdec_emit.sv
hw/rtl/shift_jis_to_utf8_decoder_unit.sv
sim/tb_shift_jis_to_utf8_decoder_unit.sv
